FILE: design/plsu_pkg.sv
package plsu_pkg;

  localparam int THREAD_COUNT = 16;
  localparam int TID_W        = $clog2(THREAD_COUNT);
  localparam int PRIO_W       = 8;
  localparam int OP_W         = 3;
  localparam int IN_W         = 16;
  localparam int OUT_W        = 16;

  localparam logic [OP_W-1:0] OP_SCHED   = 3'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
  localparam logic [OP_W-1:0] OP_FINISH  = 3'd2;
  localparam logic [OP_W-1:0] OP_LOCK    = 3'd3;
  localparam logic [OP_W-1:0] OP_UNLOCK  = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic latch;         // capture input item
    logic scan_init;     // reset scan counter and running best
    logic scan_rd;       // read entry at scan index, advance
    logic sched_commit;  // fold last compare into found flag
    logic rd_tid;        // read priority of requester
    logic rd_owner;      // read priority of owner, keep requester priority
    logic lock_exec;     // apply lock decision
    logic simple_exec;   // apply release / finish / unlock
    logic load_out;      // load result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: design/plsu_ctrl.sv
module plsu_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [plsu_pkg::OP_W-1:0] in_op,
  input  plsu_pkg::dp_status_t     st,
  output plsu_pkg::dp_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_RD_T,
    S_RD_O,
    S_LOCK,
    S_EXEC,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch     = 1'b1;
          cmd.scan_init = 1'b1;
          case (in_op)
            plsu_pkg::OP_SCHED:   state_next = S_SCAN;
            plsu_pkg::OP_LOCK:    state_next = S_RD_T;
            plsu_pkg::OP_RELEASE: state_next = S_EXEC;
            plsu_pkg::OP_FINISH:  state_next = S_EXEC;
            plsu_pkg::OP_UNLOCK:  state_next = S_EXEC;
            default:              state_next = S_OUT;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (st.scan_last) state_next = S_SCAN_END;
      end
      S_SCAN_END: begin
        cmd.sched_commit = 1'b1;
        state_next       = S_OUT;
      end
      S_RD_T: begin
        cmd.rd_tid = 1'b1;
        state_next = S_RD_O;
      end
      S_RD_O: begin
        cmd.rd_owner = 1'b1;
        state_next   = S_LOCK;
      end
      S_LOCK: begin
        cmd.lock_exec = 1'b1;
        state_next    = S_OUT;
      end
      S_EXEC: begin
        cmd.simple_exec = 1'b1;
        state_next      = S_OUT;
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/plsu_dp.sv
module plsu_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic                        cfg_wdata,
  input  logic [plsu_pkg::OP_W-1:0]   in_op,
  input  logic [plsu_pkg::TID_W-1:0]  in_tid,
  input  logic [plsu_pkg::PRIO_W-1:0] in_prio,
  input  plsu_pkg::dp_cmd_t           cmd,
  output plsu_pkg::dp_status_t        st,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [plsu_pkg::OUT_W-1:0]  m_tdata
);

  // priority table: one write port, one registered read port
  logic [plsu_pkg::PRIO_W-1:0] prio_mem [plsu_pkg::THREAD_COUNT];
  logic [plsu_pkg::THREAD_COUNT-1:0] pv;        // entry written since reset
  logic [plsu_pkg::THREAD_COUNT-1:0] runnable;

  logic [plsu_pkg::OP_W-1:0]   op_q;
  logic [plsu_pkg::TID_W-1:0]  tid_q;
  logic [plsu_pkg::PRIO_W-1:0] np_q;

  logic                        ceiling_mode;
  logic [plsu_pkg::TID_W-1:0]  owner_idx;
  logic                        owner_valid;
  logic [plsu_pkg::PRIO_W-1:0] saved_prio;
  logic                        boost_active;
  logic [plsu_pkg::TID_W-1:0]  waiter_idx;
  logic                        waiter_valid;
  logic [plsu_pkg::PRIO_W-1:0] ceiling_level;
  logic [plsu_pkg::TID_W-1:0]  chosen;
  logic                        found;
  logic                        granted;
  logic                        blocked;

  logic [plsu_pkg::TID_W-1:0]  scan_idx;
  logic                        cmp_v;
  logic [plsu_pkg::TID_W-1:0]  cmp_idx;
  logic [plsu_pkg::PRIO_W-1:0] best;
  logic                        any_hit;

  logic [plsu_pkg::TID_W-1:0]  rd_addr;
  logic [plsu_pkg::PRIO_W-1:0] rd_data;
  logic                        rd_valid;
  logic [plsu_pkg::PRIO_W-1:0] prio_rd;
  logic [plsu_pkg::PRIO_W-1:0] req_prio;

  logic                        wr_en;
  logic [plsu_pkg::TID_W-1:0]  wr_addr;
  logic [plsu_pkg::PRIO_W-1:0] wr_data;

  logic                        scan_hit;
  logic [plsu_pkg::PRIO_W-1:0] ceil_new;
  logic                        lock_wait;
  logic                        lock_boost;
  logic                        unlock_ok;

  assign prio_rd  = rd_valid ? rd_data : '0;
  assign scan_hit = cmp_v && runnable[cmp_idx] && (prio_rd > best);

  assign rd_addr = cmd.rd_owner ? owner_idx :
                   cmd.rd_tid   ? tid_q     : scan_idx;

  assign ceil_new   = (ceiling_mode && (ceiling_level <= req_prio)) ? req_prio : ceiling_level;
  assign lock_wait  = owner_valid && (owner_idx != tid_q) &&
                      !(waiter_valid && (waiter_idx != tid_q));
  assign lock_boost = lock_wait && (prio_rd < req_prio);
  assign unlock_ok  = (op_q == plsu_pkg::OP_UNLOCK) && owner_valid && (owner_idx == tid_q);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tid_q;
    wr_data = np_q;
    if (cmd.simple_exec) begin
      case (op_q)
        plsu_pkg::OP_RELEASE: wr_en = 1'b1;
        plsu_pkg::OP_FINISH: begin
          wr_en   = 1'b1;
          wr_data = '0;
        end
        plsu_pkg::OP_UNLOCK: begin
          wr_en   = unlock_ok && boost_active;
          wr_addr = owner_idx;
          wr_data = saved_prio;
        end
        default: wr_en = 1'b0;
      endcase
    end else if (cmd.lock_exec) begin
      wr_en   = lock_boost;
      wr_addr = owner_idx;
      wr_data = ceiling_mode ? ceil_new : req_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) prio_mem[wr_addr] <= wr_data;
    rd_data <= prio_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv            <= '0;
      runnable      <= '0;
      rd_valid      <= 1'b0;
      ceiling_mode  <= 1'b0;
      owner_idx     <= '0;
      owner_valid   <= 1'b0;
      saved_prio    <= '0;
      boost_active  <= 1'b0;
      waiter_idx    <= '0;
      waiter_valid  <= 1'b0;
      ceiling_level <= '0;
      chosen        <= '0;
      found         <= 1'b0;
      granted       <= 1'b0;
      blocked       <= 1'b0;
      scan_idx      <= '0;
      cmp_v         <= 1'b0;
      cmp_idx       <= '0;
      best          <= '0;
      any_hit       <= 1'b0;
      req_prio      <= '0;
      op_q          <= '0;
      tid_q         <= '0;
      np_q          <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_wen) ceiling_mode <= cfg_wdata;

      rd_valid <= pv[rd_addr];
      if (wr_en) pv[wr_addr] <= 1'b1;

      cmp_v   <= cmd.scan_rd;
      cmp_idx <= scan_idx;

      if (cmd.latch) begin
        op_q    <= in_op;
        tid_q   <= in_tid;
        np_q    <= in_prio;
        granted <= 1'b0;
        blocked <= 1'b0;
      end

      if (cmd.scan_init) begin
        scan_idx <= plsu_pkg::TID_W'(1);
        best     <= '0;
        any_hit  <= 1'b0;
      end else if (cmd.scan_rd) begin
        scan_idx <= scan_idx + plsu_pkg::TID_W'(1);
      end

      if (scan_hit) begin
        best    <= prio_rd;
        chosen  <= cmp_idx;
        any_hit <= 1'b1;
      end
      if (cmd.sched_commit) found <= any_hit | scan_hit;

      if (cmd.rd_owner) req_prio <= prio_rd;

      if (cmd.simple_exec) begin
        case (op_q)
          plsu_pkg::OP_RELEASE: runnable[tid_q] <= 1'b1;
          plsu_pkg::OP_UNLOCK: begin
            if (unlock_ok) begin
              boost_active <= 1'b0;
              if (waiter_valid) begin
                runnable[waiter_idx] <= 1'b1;
                owner_idx            <= waiter_idx;
                waiter_valid         <= 1'b0;
                waiter_idx           <= '0;
              end else begin
                owner_valid <= 1'b0;
                owner_idx   <= '0;
              end
            end
          end
          default: ;
        endcase
      end

      if (cmd.lock_exec) begin
        ceiling_level <= ceil_new;
        if (!owner_valid) begin
          owner_idx    <= tid_q;
          owner_valid  <= 1'b1;
          boost_active <= 1'b0;
          granted      <= 1'b1;
        end else if (lock_wait) begin
          if (lock_boost) begin
            if (!boost_active) saved_prio <= prio_rd;
            boost_active <= 1'b1;
          end
          runnable[tid_q] <= 1'b0;
          waiter_idx      <= tid_q;
          waiter_valid    <= 1'b1;
          blocked         <= 1'b1;
        end
      end

      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {3'b000,
                  owner_valid && boost_active,
                  owner_valid,
                  owner_valid ? owner_idx : {plsu_pkg::TID_W{1'b0}},
                  blocked,
                  granted,
                  found,
                  chosen};
    end
  end

  assign st.scan_last = (scan_idx == plsu_pkg::TID_W'(plsu_pkg::THREAD_COUNT - 1));
  assign st.out_busy  = m_tvalid && !m_tready;

endmodule

FILE: design/priority_inheritance_lock_scheduler_unit.sv
// Path from input accept to result valid: schedule scans the priority table, lock reads
// requester and owner priority then decides, release / finish / unlock execute directly.
// Other codes go straight to the result register.
// One item in flight; the next item is taken the cycle after its result is loaded.
// Schedule scans one entry per cycle over the priority table read port; lock costs two reads of that port.
// Reset (rst, synchronous, active high) clears all control state and the table valid bits.
module priority_inheritance_lock_scheduler_unit (
  input  logic                        clk,
  input  logic                        rst,
  // config: ceiling_mode
  input  logic                        cfg_wen,
  input  logic                        cfg_wdata,
  // input item
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [2:0] operation, [6:3] thread_id, [14:7] new_priority, [15] zero
  input  logic [plsu_pkg::IN_W-1:0]   s_tdata,
  // result item
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [3:0] active_thread, [4] active_found, [5] lock_granted, [6] lock_blocked,
  // [10:7] lock_holder, [11] lock_held, [12] holder_boosted, [15:13] zero
  output logic [plsu_pkg::OUT_W-1:0]  m_tdata
);

  plsu_pkg::dp_cmd_t    cmd;
  plsu_pkg::dp_status_t st;

  logic [plsu_pkg::OP_W-1:0]   in_op;
  logic [plsu_pkg::TID_W-1:0]  in_tid;
  logic [plsu_pkg::PRIO_W-1:0] in_prio;

  // unpack input fields
  assign in_op   = s_tdata[2:0];
  assign in_tid  = s_tdata[6:3];
  assign in_prio = s_tdata[14:7];

  // sequencer: one item at a time, waits in its output state only while the
  // result register is still full
  plsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_op    (in_op),
    .st       (st),
    .cmd      (cmd)
  );

  // thread table, lock state, scan unit and result register
  plsu_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_op     (in_op),
    .in_tid    (in_tid),
    .in_prio   (in_prio),
    .cmd       (cmd),
    .st        (st),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // a boosted holder implies a held lock
  a_boost_needs_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[12] && !m_tdata[11]))
    else $error("holder_boosted without lock_held");

  // one lock op cannot both grant and block
  a_grant_xor_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[5] && m_tdata[6]))
    else $error("lock granted and blocked together");

  // an accepted item closes the input until its result is loaded
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while one in flight");

  // result load never coincides with input acceptance
  a_load_not_idle: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && cmd.load_out))
    else $error("result loaded while idle");

endmodule
